[rtl/krtc_pkg.sv]
// Shared types, codes and widths for the keyed record table completion core.
`timescale 1ns / 1ps

package krtc_pkg;

	localparam int RECORDS_DEF   = 8;
	localparam int SLOTS_DEF     = 5;
	localparam int FRAME_MAX_DEF = 512;

	localparam int OP_W       = 2;
	localparam int KEY_W      = 48;
	localparam int SLOT_NUM_W = 3;
	localparam int LEN_W      = 16;
	localparam int TAG_W      = 8;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 7;

	typedef enum logic [OP_W-1:0] {
		OP_SIDE     = 2'd0,
		OP_NUMBERED = 2'd1,
		OP_ACK      = 2'd2,
		OP_NOP      = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_BAD_SLOT  = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	localparam logic [SLOT_NUM_W-1:0] SLOT_SIDE  = 3'd0;
	localparam logic [SLOT_NUM_W-1:0] SLOT_FIRST = 3'd1;
	localparam logic [SLOT_NUM_W-1:0] SLOT_LAST  = 3'd4;
	localparam int SLOT_PAIR_A = 2;
	localparam int SLOT_PAIR_B = 3;

	localparam logic [TAG_W-1:0] TAG_FIRST = 8'd1;

	typedef struct packed {
		logic load;
		logic match;
		logic apply;
	} krtc_cmd_t;

	typedef struct packed {
		logic out_busy;
	} krtc_stat_t;

endpackage

[rtl/krtc_ctrl.sv]
// Controller state machine: sequences capture, match and apply of one beat.
`timescale 1ns / 1ps

module krtc_ctrl
	import krtc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output krtc_cmd_t  cmd,
	input  krtc_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_MATCH = 3'b010,
		S_APPLY = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MATCH;
				end
			end
			S_MATCH: begin
				cmd.match = 1'b1;
				state_d   = S_APPLY;
			end
			S_APPLY: begin
				// The table is only touched when the result register can take the beat.
				if (!stat.out_busy) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/krtc_dpath.sv]
// Datapath: record table, parallel key and id match, update logic and result register.
`timescale 1ns / 1ps

module krtc_dpath
	import krtc_pkg::*;
#(
	parameter int RECORDS   = RECORDS_DEF,
	parameter int SLOTS     = SLOTS_DEF,
	parameter int FRAME_MAX = FRAME_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  krtc_cmd_t             cmd,
	output krtc_stat_t            stat,
	input  logic [OP_W-1:0]       operation,
	input  logic [KEY_W-1:0]      key,
	input  logic [SLOT_NUM_W-1:0] slot_number,
	input  logic [LEN_W-1:0]      item_length,
	input  logic [TAG_W-1:0]      ack_id,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic                  just_completed,
	output logic [TAG_W-1:0]      record_id,
	output logic [COUNT_W-1:0]    complete_count,
	output logic                  any_pending
);

	localparam int IDX_W = (RECORDS > 1) ? $clog2(RECORDS) : 1;
	localparam int CNT_W = $clog2(RECORDS + 1);

	// Table state
	logic [RECORDS-1:0] valid_q;
	logic [RECORDS-1:0] complete_q;
	logic [TAG_W-1:0]   tag_q  [RECORDS];
	logic [KEY_W-1:0]   key_q  [RECORDS];
	logic [SLOTS-1:0]   fill_q [RECORDS];
	logic [TAG_W-1:0]   next_tag_q;
	logic [CNT_W-1:0]   cnt_q;

	// Captured beat
	op_t                   op_q;
	logic [KEY_W-1:0]      in_key_q;
	logic [SLOT_NUM_W-1:0] slot_q;
	logic [LEN_W-1:0]      len_q;
	logic [TAG_W-1:0]      ack_q;

	// Match vectors
	logic [RECORDS-1:0] hit_d, tag_hit_d;
	logic [RECORDS-1:0] hit_q, tag_hit_q, free_q, evict_q;

	// Result register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic                fresh_q;
	logic [TAG_W-1:0]    id_q;
	logic [COUNT_W-1:0]  count_q;
	logic                pending_q;

	// Apply logic
	status_t               st_d;
	logic                  wr_en, claim, clear, make_complete, len_ok, slot_ok;
	logic [IDX_W-1:0]      wr_idx;
	logic [SLOTS-1:0]      row_old, row_new;
	logic                  comp_old;
	logic [SLOT_NUM_W-1:0] slot_sel;
	logic [TAG_W-1:0]      tag_inc;
	logic [CNT_W-1:0]      cnt_d;

	function automatic logic [IDX_W-1:0] first_set(input logic [RECORDS-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = RECORDS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

	assign stat.out_busy = out_valid_q && !out_ready;

	always_comb begin
		for (int i = 0; i < RECORDS; i++) begin
			hit_d[i]     = valid_q[i] && (key_q[i] == in_key_q);
			tag_hit_d[i] = valid_q[i] && complete_q[i] && (tag_q[i] == ack_q);
		end
	end

	always_comb begin
		len_ok  = (len_q != '0) && (len_q <= LEN_W'(FRAME_MAX));
		slot_ok = (slot_q >= SLOT_FIRST) && (slot_q <= SLOT_LAST);
		st_d    = ST_DONE;
		wr_en   = 1'b0;
		claim   = 1'b0;
		clear   = 1'b0;
		wr_idx  = first_set(hit_q);
		case (op_q)
			OP_SIDE: begin
				if (|hit_q) begin
					wr_en = 1'b1;
				end else begin
					st_d = ST_NOT_FOUND;
				end
			end
			OP_NUMBERED: begin
				if (!slot_ok) begin
					st_d = ST_BAD_SLOT;
				end else if (|hit_q) begin
					wr_en = 1'b1;
				end else if (|free_q) begin
					wr_en  = 1'b1;
					claim  = 1'b1;
					wr_idx = first_set(free_q);
				end else if (|evict_q) begin
					// Full table: reuse the lowest-numbered record that is still incomplete.
					wr_en  = 1'b1;
					claim  = 1'b1;
					wr_idx = first_set(evict_q);
				end else begin
					st_d = ST_FULL;
				end
			end
			OP_ACK: begin
				if (|tag_hit_q) begin
					clear  = 1'b1;
					wr_idx = first_set(tag_hit_q);
				end else begin
					st_d = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase

		slot_sel = (op_q == OP_SIDE) ? SLOT_SIDE : slot_q;
		row_old  = claim ? '0 : fill_q[wr_idx];
		row_new  = row_old | (len_ok ? (SLOTS'(1) << slot_sel) : '0);
		comp_old = claim ? 1'b0 : complete_q[wr_idx];
		make_complete = wr_en && (op_q == OP_NUMBERED) && row_new[SLOT_PAIR_A]
			&& row_new[SLOT_PAIR_B] && !comp_old;

		tag_inc = next_tag_q + TAG_W'(1);
		if (tag_inc == '0) begin
			tag_inc = TAG_FIRST;
		end

		cnt_d = cnt_q + CNT_W'(make_complete) - CNT_W'(clear);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			complete_q  <= '0;
			next_tag_q  <= TAG_FIRST;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.apply) begin
				out_valid_q <= 1'b1;
				cnt_q       <= cnt_d;
				if (wr_en) begin
					valid_q[wr_idx] <= 1'b1;
					// A claimed record starts incomplete unless this beat completes it.
					if (claim || make_complete) begin
						complete_q[wr_idx] <= make_complete;
					end
				end
				if (clear) begin
					valid_q[wr_idx]    <= 1'b0;
					complete_q[wr_idx] <= 1'b0;
				end
				if (make_complete) begin
					next_tag_q <= tag_inc;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(operation);
			in_key_q <= key;
			slot_q   <= slot_number;
			len_q    <= item_length;
			ack_q    <= ack_id;
		end
		if (cmd.match) begin
			hit_q     <= hit_d;
			tag_hit_q <= tag_hit_d;
			free_q    <= ~valid_q;
			evict_q   <= ~complete_q;
		end
		if (cmd.apply) begin
			if (wr_en) begin
				fill_q[wr_idx] <= row_new;
			end
			if (claim) begin
				key_q[wr_idx] <= in_key_q;
			end
			if (make_complete) begin
				tag_q[wr_idx] <= next_tag_q;
			end
			if (clear) begin
				fill_q[wr_idx] <= '0;
			end
			status_q  <= st_d;
			fresh_q   <= make_complete;
			id_q      <= make_complete ? next_tag_q : '0;
			count_q   <= COUNT_W'(cnt_d);
			pending_q <= (cnt_d != '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign just_completed = fresh_q;
	assign record_id      = id_q;
	assign complete_count = count_q;
	assign any_pending    = pending_q;

endmodule

[rtl/keyed_record_table_completion_core.sv]
// Timing: a result beat is registered after its input beat passes capture at acceptance,
// then match, then apply; apply waits while the previous result is not taken.
// Flow: a new beat is not accepted until the previous one has passed capture, match and
// apply; the next beat is taken while a finished result waits in the output register.
// Reset: arst_n clears all records, the complete count and the control state, and sets the
// id counter to one; it takes effect at once with no clearing pass.
`timescale 1ns / 1ps

module keyed_record_table_completion_core
	import krtc_pkg::*;
#(
	parameter int RECORDS   = RECORDS_DEF,
	parameter int SLOTS     = SLOTS_DEF,
	parameter int FRAME_MAX = FRAME_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OP_W-1:0]       operation,
	input  logic [KEY_W-1:0]      key,
	input  logic [SLOT_NUM_W-1:0] slot_number,
	input  logic [LEN_W-1:0]      item_length,
	input  logic [TAG_W-1:0]      ack_id,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic                  just_completed,
	output logic [TAG_W-1:0]      record_id,
	output logic [COUNT_W-1:0]    complete_count,
	output logic                  any_pending
);

	krtc_cmd_t  cmd;
	krtc_stat_t stat;

	krtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	krtc_dpath #(
		.RECORDS   (RECORDS),
		.SLOTS     (SLOTS),
		.FRAME_MAX (FRAME_MAX)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.operation      (operation),
		.key            (key),
		.slot_number    (slot_number),
		.item_length    (item_length),
		.ack_id         (ack_id),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.just_completed (just_completed),
		.record_id      (record_id),
		.complete_count (complete_count),
		.any_pending    (any_pending)
	);

`ifndef SYNTHESIS
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && just_completed |-> record_id != '0 && status == ST_DONE)
		else $error("completion beat without a usable record id");

	a_pending_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> any_pending == (complete_count != '0))
		else $error("any_pending disagrees with complete_count");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> complete_count <= COUNT_W'(RECORDS))
		else $error("complete_count exceeds the number of records");

	a_id_zero_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !just_completed |-> record_id == '0)
		else $error("record_id set on a beat that completed nothing");
`endif

endmodule
